[rtl/core/npcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types, palette ROM and compare helper for the nearest palette
// color search.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int ROM_SIZE        = 64;
  localparam int PALETTE_ENTRIES = 64;
  localparam int LEAVES          = 64;
  localparam int CHAN_W          = 8;
  localparam int SQ_W            = 2 * CHAN_W;
  localparam int IDX_W           = 6;
  localparam int DIST_W          = 18;
  localparam int DIST_LIMIT      = 195075;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } cand_t;

  localparam logic [3*CHAN_W-1:0] PALETTE_ROM [ROM_SIZE] = '{
    24'h000000, 24'h290514, 24'h2A0507, 24'h230F06,
    24'h1E1306, 24'h1A1605, 24'h141807, 24'h061A07,
    24'h051A13, 24'h071918, 24'h08181C, 24'h071722,
    24'h030B3D, 24'h16033A, 24'h20052D, 24'h260420,
    24'h363636, 24'h740A40, 24'h77091A, 24'h693512,
    24'h5D3F0E, 24'h514617, 24'h424C19, 24'h13511A,
    24'h16503F, 24'h114E4D, 24'h164D58, 24'h164A66,
    24'h163794, 24'h472990, 24'h5F167D, 24'h6C115F,
    24'h949494, 24'hC04A7A, 24'hC54A4D, 24'hB8601B,
    24'hA27326, 24'h8F7E2F, 24'h77872D, 24'h209030,
    24'h2E8E72, 24'h318B89, 24'h1F889C, 24'h2483B5,
    24'h4D77D7, 24'h7E6AD3, 24'h9D5DBF, 24'hB352A0,
    24'hFFFFFF, 24'hF1A2BB, 24'hF1A6A1, 24'hF1A983,
    24'hEEAC44, 24'hD4BA33, 24'hB0C841, 24'h73D275,
    24'h22D0A6, 24'h3BCDC9, 24'h48C9E4, 24'h88C4ED,
    24'hA4BDEF, 24'hBBB5F1, 24'hD5A9EF, 24'hF09BDD
  };

  function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a,
                                                logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic cand_t pick_min(cand_t lo, cand_t hi);
    return (hi.sq_dist < lo.sq_dist) ? hi : lo;
  endfunction

endpackage
`default_nettype wire

[rtl/core/npcs_dist.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_dist
// Three-stage per-entry distance lanes: absolute channel difference,
// squares, then three-way sum.
// ----------------------------------------------------------------------------
module npcs_dist
  import npcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire pixel_t            up_pixel,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output logic [DIST_W-1:0]      dn_dist [LEAVES]
);

  logic              v1_r, v2_r, v3_r;
  logic              adv1, adv2, adv3;
  logic [CHAN_W-1:0] dr_r [PALETTE_ENTRIES];
  logic [CHAN_W-1:0] dg_r [PALETTE_ENTRIES];
  logic [CHAN_W-1:0] db_r [PALETTE_ENTRIES];
  logic [SQ_W-1:0]   sr_r [PALETTE_ENTRIES];
  logic [SQ_W-1:0]   sg_r [PALETTE_ENTRIES];
  logic [SQ_W-1:0]   sb_r [PALETTE_ENTRIES];
  logic [DIST_W-1:0] sum_r [PALETTE_ENTRIES];

  assign adv3     = !v3_r || dn_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign dn_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PALETTE_ENTRIES; k++) begin
      if (adv1) begin
        dr_r[k] <= abs_diff(up_pixel.red_in,   PALETTE_ROM[k][3*CHAN_W-1:2*CHAN_W]);
        dg_r[k] <= abs_diff(up_pixel.green_in, PALETTE_ROM[k][2*CHAN_W-1:CHAN_W]);
        db_r[k] <= abs_diff(up_pixel.blue_in,  PALETTE_ROM[k][CHAN_W-1:0]);
      end
      if (adv2) begin
        sr_r[k] <= SQ_W'(dr_r[k]) * SQ_W'(dr_r[k]);
        sg_r[k] <= SQ_W'(dg_r[k]) * SQ_W'(dg_r[k]);
        sb_r[k] <= SQ_W'(db_r[k]) * SQ_W'(db_r[k]);
      end
      if (adv3) begin
        sum_r[k] <= DIST_W'(sr_r[k]) + DIST_W'(sg_r[k]) + DIST_W'(sb_r[k]);
      end
    end
  end

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < PALETTE_ENTRIES) begin : g_on
      assign dn_dist[k] = sum_r[k];
    end else begin : g_off
      assign dn_dist[k] = {DIST_W{1'b1}};
    end
  end

endmodule
`default_nettype wire

[rtl/core/npcs_min_tree.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_min_tree
// Registered minimum tree over all leaves, two compare levels per stage;
// the lower index wins on equal distance.
// ----------------------------------------------------------------------------
module npcs_min_tree
  import npcs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire logic [DIST_W-1:0] up_dist [LEAVES],
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output result_t                dn_result
);

  localparam int L1 = LEAVES / 4;
  localparam int L2 = L1 / 4;

  logic  v1_r, v2_r, v3_r;
  logic  adv1, adv2, adv3;
  cand_t leaf  [LEAVES];
  cand_t lvl1_nxt [L1];
  cand_t lvl2_nxt [L2];
  cand_t best_nxt;
  cand_t lvl1_r [L1];
  cand_t lvl2_r [L2];
  cand_t best_r;

  assign adv3     = !v3_r || dn_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign dn_valid = v3_r;

  always_comb begin
    for (int k = 0; k < LEAVES; k++) begin
      leaf[k].idx     = IDX_W'(k);
      leaf[k].sq_dist = up_dist[k];
    end
    for (int i = 0; i < L1; i++) begin
      lvl1_nxt[i] = pick_min(pick_min(leaf[4*i],     leaf[4*i+1]),
                             pick_min(leaf[4*i+2],   leaf[4*i+3]));
    end
    for (int i = 0; i < L2; i++) begin
      lvl2_nxt[i] = pick_min(pick_min(lvl1_r[4*i],   lvl1_r[4*i+1]),
                             pick_min(lvl1_r[4*i+2], lvl1_r[4*i+3]));
    end
    best_nxt = pick_min(pick_min(lvl2_r[0], lvl2_r[1]),
                        pick_min(lvl2_r[2], lvl2_r[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) lvl1_r <= lvl1_nxt;
    if (adv2) lvl2_r <= lvl2_nxt;
    if (adv3) best_r <= best_nxt;
  end

  assign dn_result.best_index    = best_r.idx;
  assign dn_result.best_distance = best_r.sq_dist;

endmodule
`default_nettype wire

[rtl/core/nearest_palette_color_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Matches an RGB pixel against a fixed 64-entry palette and returns the
// index and squared distance of the closest entry.
//
// Input channel: in_valid / in_ready / in_pixel carry one 8-bit-per-channel
// pixel per transaction. Result channel: out_valid / out_ready / out_result
// carry the best palette index (lowest index on equal distance) and its
// squared RGB distance.
// Pipeline: three stages of per-entry distance lanes (difference, square,
// sum) followed by a three-stage registered minimum tree. Throughput is
// one pixel per cycle while the receiver keeps out_ready high, set by the
// fully parallel lanes that cover every palette entry.
// A stalled receiver freezes the last stage; earlier stages keep filling
// bubbles, and in_ready falls only once all six stages hold data.
// Reset clears every stage valid bit; no results are pending afterwards.
// ----------------------------------------------------------------------------
module nearest_palette_color_search
  import npcs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire pixel_t  in_pixel,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic              mid_valid;
  logic              mid_ready;
  logic [DIST_W-1:0] mid_dist [LEAVES];

  npcs_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_pixel (in_pixel),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_dist  (mid_dist)
  );

  npcs_min_tree u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_dist   (mid_dist),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .dn_result (out_result)
  );

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.best_distance <= DIST_W'(DIST_LIMIT))
    else $error("best_distance above channel bound");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_result.best_index} < (IDX_W+1)'(PALETTE_ENTRIES))
    else $error("best_index outside active palette");

  a_backpressure_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  a_mid_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !mid_ready |-> out_valid && !out_ready)
    else $error("tree stalled without output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

[bench/tb_nearest_palette_color_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search
// Self-checking bench for the nearest palette color search. A table of
// probe pixels (palette hits, channel extremes, near-ties) runs first. A long
// random stream follows: uniform pixels, jittered and exact palette colors,
// and midpoints between entries. Every result is compared in order against
// a typed result or a bench-side nearest-color model with its own palette copy.
// Both channels idle at random, and the receiver holds off long enough to
// back the pipeline up into in_ready.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search;
  import npcs_pkg::*;

  localparam int SWATCH_COUNT = 64;
  localparam int RANDOM_PIXELS = 1300;
  localparam int NUM_PROBES = 19;
  localparam int MAX_PRINTS = 100;
  localparam int DRAIN_CYCLES = 16;
  localparam logic TYPED = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam logic [23:0] SWATCH [SWATCH_COUNT] = '{
    24'h000000, 24'h290514, 24'h2A0507, 24'h230F06,
    24'h1E1306, 24'h1A1605, 24'h141807, 24'h061A07,
    24'h051A13, 24'h071918, 24'h08181C, 24'h071722,
    24'h030B3D, 24'h16033A, 24'h20052D, 24'h260420,
    24'h363636, 24'h740A40, 24'h77091A, 24'h693512,
    24'h5D3F0E, 24'h514617, 24'h424C19, 24'h13511A,
    24'h16503F, 24'h114E4D, 24'h164D58, 24'h164A66,
    24'h163794, 24'h472990, 24'h5F167D, 24'h6C115F,
    24'h949494, 24'hC04A7A, 24'hC54A4D, 24'hB8601B,
    24'hA27326, 24'h8F7E2F, 24'h77872D, 24'h209030,
    24'h2E8E72, 24'h318B89, 24'h1F889C, 24'h2483B5,
    24'h4D77D7, 24'h7E6AD3, 24'h9D5DBF, 24'hB352A0,
    24'hFFFFFF, 24'hF1A2BB, 24'hF1A6A1, 24'hF1A983,
    24'hEEAC44, 24'hD4BA33, 24'hB0C841, 24'h73D275,
    24'h22D0A6, 24'h3BCDC9, 24'h48C9E4, 24'h88C4ED,
    24'hA4BDEF, 24'hBBB5F1, 24'hD5A9EF, 24'hF09BDD
  };

  typedef struct packed {
    pixel_t  pix;
    logic    known;
    result_t res;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    {24'h000000, TYPED,     6'd0,  18'd0},
    {24'hFFFFFF, TYPED,     6'd48, 18'd0},
    {24'h290514, TYPED,     6'd1,  18'd0},
    {24'hF09BDD, TYPED,     6'd63, 18'd0},
    {24'h363636, TYPED,     6'd16, 18'd0},
    {24'h949494, TYPED,     6'd32, 18'd0},
    {24'h010000, TYPED,     6'd0,  18'd1},
    {24'hFEFEFE, TYPED,     6'd48, 18'd3},
    {24'hFF0000, PREDICTED, 6'd0,  18'd0},
    {24'h00FF00, PREDICTED, 6'd0,  18'd0},
    {24'h0000FF, PREDICTED, 6'd0,  18'd0},
    {24'hFFFF00, PREDICTED, 6'd0,  18'd0},
    {24'hFF00FF, PREDICTED, 6'd0,  18'd0},
    {24'h00FFFF, PREDICTED, 6'd0,  18'd0},
    {24'h1B1B1B, PREDICTED, 6'd0,  18'd0},
    {24'h808080, PREDICTED, 6'd0,  18'd0},
    {24'h7F7F7F, PREDICTED, 6'd0,  18'd0},
    {24'hAA55AA, PREDICTED, 6'd0,  18'd0},
    {24'h55AA55, PREDICTED, 6'd0,  18'd0}
  };

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  pixel_t  in_pixel = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_result;

  result_t nearest_q [$];
  int      mismatches = 0;
  int      results_seen = 0;

  nearest_palette_color_search u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  always #5 clk = ~clk;

  function automatic result_t find_nearest(pixel_t p);
    result_t best;
    int      best_d;
    int      dr;
    int      dg;
    int      db;
    int      d;
    best = '0;
    best_d = 0;
    for (int k = 0; k < SWATCH_COUNT; k++) begin
      dr = int'(p.red_in) - int'(SWATCH[k][23:16]);
      dg = int'(p.green_in) - int'(SWATCH[k][15:8]);
      db = int'(p.blue_in) - int'(SWATCH[k][7:0]);
      d = dr * dr + dg * dg + db * db;
      if (k == 0 || d < best_d) begin
        best_d = d;
        best.best_index = k[IDX_W-1:0];
      end
    end
    best.best_distance = best_d[DIST_W-1:0];
    return best;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 24);
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic pixel_t make_pixel();
    pixel_t      p;
    logic [23:0] a;
    logic [23:0] b;
    int          r;
    r = $urandom_range(0, 99);
    a = SWATCH[$urandom_range(0, SWATCH_COUNT - 1)];
    b = SWATCH[$urandom_range(0, SWATCH_COUNT - 1)];
    if (r < 50) begin
      p = pixel_t'(24'($urandom));
    end else if (r < 75) begin
      p.red_in = jitter(a[23:16]);
      p.green_in = jitter(a[15:8]);
      p.blue_in = jitter(a[7:0]);
    end else if (r < 90) begin
      p = pixel_t'(a);
    end else begin
      p.red_in = 8'((int'(a[23:16]) + int'(b[23:16])) / 2);
      p.green_in = 8'((int'(a[15:8]) + int'(b[15:8])) / 2);
      p.blue_in = 8'((int'(a[7:0]) + int'(b[7:0])) / 2);
    end
    return p;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Offer one pixel and hold it until the transaction completes.
  task automatic offer_pixel(input pixel_t p, input logic known, input result_t typed_res,
                             input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (!in_ready);
    nearest_q.push_back(known ? typed_res : find_nearest(p));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (nearest_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result idx=%0d dist=%0d",
                                out_result.best_index, out_result.best_distance));
      end else begin
        want = nearest_q.pop_front();
        if (out_result.best_index !== want.best_index)
          flag_mismatch($sformatf("best_index got %0d want %0d",
                                  out_result.best_index, want.best_index));
        if (out_result.best_distance !== want.best_distance)
          flag_mismatch($sformatf("best_distance got %0d want %0d",
                                  out_result.best_distance, want.best_distance));
      end
    end
  end

  initial begin : drain_side
    int stall;
    int holds_done;
    holds_done = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= 300 + 500 * holds_done) begin
        stall = 80;
        holds_done++;
      end else if ((results_seen % 300) >= 150 && (results_seen % 300) < 190) begin
        stall = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : pixel_side
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (PROBES[i]) offer_pixel(PROBES[i].pix, PROBES[i].known, PROBES[i].res, 1'b0);
    for (int i = 0; i < RANDOM_PIXELS; i++)
      offer_pixel(make_pixel(), PREDICTED, '0, (i % 300) < 40);
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
